/* src/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Item payload structs, command and status codes, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Operation codes carried in an input item
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    cmd_e                     command;
    logic signed [DataW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  removed_value;
    logic [CountW-1:0]        entry_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic exec;   // carry out the operation on store and pointers
    logic load;   // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } dp_stat_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_RESULT = 2'd2
  } state_e;

endpackage

/* src/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl: operation sequencer
// Takes one item at a time: capture, execute, then hand the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dq_pkg::dp_stat_t  stat_i,
  output dq_pkg::ctrl_cmd_t cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_RESULT: begin
        cmd_o.load = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath: ring buffer storage, pointers and result register
// Holds the entry memory, front slot and occupancy, works out the slot for
// each operation with a single wrap compare, and registers the result.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dq_pkg::in_item_t   in_item_i,
  input  dq_pkg::ctrl_cmd_t  cmd_i,
  output dq_pkg::dp_stat_t   stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dq_pkg::out_item_t  out_item_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  // Captured item
  cmd_e                    cmd_q;
  logic signed [DataW-1:0] val_q;

  // Pointer state
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;

  // Pending result
  status_e           res_status_q, res_status_d;
  logic              res_pop_q, res_pop_d;
  logic [CountW-1:0] res_count_q, res_count_d;

  // Memory
  logic [DataW-1:0]  mem_q [DEPTH];
  logic [DataW-1:0]  rd_data_q;
  logic              we, re;
  logic [AW-1:0]     addr;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic          is_pop, full, empty;
  logic [CW-1:0] offset;
  logic [SW-1:0] sum;
  logic [AW-1:0] back_slot, front_prev, front_next;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_item_i.command;
      val_q <= in_item_i.value;
    end
  end

  // Slot arithmetic: front plus offset, wrapped once
  assign is_pop = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
  assign full   = (occ_q == DepthC);
  assign empty  = (occ_q == '0);
  assign offset = is_pop ? (occ_q - CW'(1)) : occ_q;
  assign sum    = SW'(front_q) + SW'(offset);
  assign back_slot  = (sum >= DepthS) ? AW'(sum - DepthS) : AW'(sum);
  assign front_prev = (front_q == '0) ? LastSlot : (front_q - AW'(1));
  assign front_next = (front_q == LastSlot) ? '0 : (front_q + AW'(1));

  // Operation decode
  always_comb begin
    front_d      = front_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_pop_d    = res_pop_q;
    we           = 1'b0;
    re           = 1'b0;
    addr         = back_slot;
    if (cmd_i.exec) begin
      res_pop_d    = is_pop;
      res_status_d = ST_OK;
      case (cmd_q)
        CMD_PUSH_FRONT: begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            addr    = front_prev;
            we      = 1'b1;
            front_d = front_prev;
            occ_d   = occ_q + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            we    = 1'b1;
            occ_d = occ_q + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            addr    = front_q;
            re      = 1'b1;
            front_d = front_next;
            occ_d   = occ_q - CW'(1);
          end
        end
        default: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            re    = 1'b1;
            occ_d = occ_q - CW'(1);
          end
        end
      endcase
    end
  end

  assign res_count_d = cmd_i.exec ? CountW'(occ_d) : res_count_q;

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= val_q;
    if (re) rd_data_q <= mem_q[addr];
  end

  // Pointer and pending result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      occ_q        <= '0;
      res_status_q <= ST_OK;
      res_pop_q    <= 1'b0;
      res_count_q  <= '0;
    end else begin
      front_q      <= front_d;
      occ_q        <= occ_d;
      res_status_q <= res_status_d;
      res_pop_q    <= res_pop_d;
      res_count_q  <= res_count_d;
    end
  end

  // Output register
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_d     = cmd_i.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_item_q.status        <= res_status_q;
      out_item_q.removed_value <= (res_pop_q && (res_status_q == ST_OK)) ? rd_data_q : '0;
      out_item_q.entry_count   <= res_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthC) else $error("occupancy above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> stat_o.out_free) else $error("result loaded over a waiting one");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !is_pop && full) |=> ($stable(occ_q) && $stable(front_q)))
    else $error("push on full changed state");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !is_pop && !full) |=> (occ_q == $past(occ_q) + CW'(1)))
    else $error("push did not grow occupancy");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_pop && !empty) |=> (occ_q == $past(occ_q) - CW'(1)))
    else $error("pop did not shrink occupancy");

endmodule

/* src/double_ended_queue_core.sv */
// Flow: an accepted item is captured, then executed with the registered memory
//   read, then loaded into the output register once that register is free.
// Throughput: one item at a time; the sequencer takes no new item until the
//   result is loaded, and a stalled output holds it until the result is taken.
// Reset: asynchronous, active low; clears front slot, occupancy and handshake
//   state. Entry memory is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue_core: ring-buffer double-ended queue
// Push or pop at either end of a DEPTH-entry ring of signed 32-bit values,
// returning status, removed value and entry count for every item.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dq_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dq_pkg::out_item_t out_item_o
);
  import dq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
